@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the vector normalization block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VN_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vector3_normalize assertion failed");
`define VN_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vector3_normalize assertion failed");
`else
`define VN_ASSERT_RST(label, clk, rst, prop)
`define VN_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hw/rtl/vn_pkg.sv @@
// Types and constants of the vector normalization block.
`default_nettype none
package vn_pkg;
  localparam int WORD_W    = 32;
  localparam int SUM_W     = 2 * WORD_W;
  localparam int SQ_STAGES = WORD_W;
  localparam int SQ_REM_W  = WORD_W + 3;
  localparam int Q_W       = 31;
  localparam int DV_STAGES = Q_W;
  localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(32'h4000_0000);

  typedef struct packed {
    logic signed [WORD_W-1:0] coord_x;
    logic signed [WORD_W-1:0] coord_y;
    logic signed [WORD_W-1:0] coord_z;
  } coord_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] unit_x;
    logic signed [WORD_W-1:0] unit_y;
    logic signed [WORD_W-1:0] unit_z;
    logic [WORD_W-1:0]        magnitude;
    logic                     was_zero;
  } result_t;

  typedef struct packed {
    logic [2:0][WORD_W-1:0] mag;
    logic [2:0]             neg;
  } side_t;
endpackage
`default_nettype wire

@@ hw/rtl/vn_sqrt.sv @@
// Pipelined square root, one result bit per stage, with the component data alongside.
`default_nettype none
module vn_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_vld,
  input  wire logic [vn_pkg::SUM_W-1:0]  in_rad,
  input  wire vn_pkg::side_t             in_side,
  output logic                           out_vld,
  output logic [vn_pkg::WORD_W-1:0]      out_root,
  output vn_pkg::side_t                  out_side
);
  import vn_pkg::*;

  logic [SQ_STAGES-1:0] vld;
  logic [SUM_W-1:0]     rad  [0:SQ_STAGES-1];
  logic [SQ_REM_W-1:0]  rem  [0:SQ_STAGES-1];
  logic [WORD_W-1:0]    root [0:SQ_STAGES-1];
  side_t                side [0:SQ_STAGES-1];

  logic [SUM_W-1:0]    c_rad   [0:SQ_STAGES-1];
  logic [SQ_REM_W-1:0] c_rem   [0:SQ_STAGES-1];
  logic [WORD_W-1:0]   c_root  [0:SQ_STAGES-1];
  logic [SQ_REM_W-1:0] c_sh    [0:SQ_STAGES-1];
  logic [SQ_REM_W-1:0] c_trial [0:SQ_STAGES-1];
  logic [SQ_STAGES-1:0] c_ge;

  always_comb begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      if (i == 0) begin
        c_rad[i]  = in_rad;
        c_rem[i]  = '0;
        c_root[i] = '0;
      end else begin
        c_rad[i]  = rad[i-1];
        c_rem[i]  = rem[i-1];
        c_root[i] = root[i-1];
      end
      c_sh[i]    = {c_rem[i][SQ_REM_W-3:0], c_rad[i][SUM_W-1:SUM_W-2]};
      c_trial[i] = {1'b0, c_root[i], 2'b01};
      c_ge[i]    = c_sh[i] >= c_trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[SQ_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQ_STAGES; i++) begin
      rad[i]  <= {c_rad[i][SUM_W-3:0], 2'b00};
      rem[i]  <= c_ge[i] ? (c_sh[i] - c_trial[i]) : c_sh[i];
      root[i] <= {c_root[i][WORD_W-2:0], c_ge[i]};
      side[i] <= (i == 0) ? in_side : side[i-1];
    end
  end

  assign out_vld  = vld[SQ_STAGES-1];
  assign out_root = root[SQ_STAGES-1];
  assign out_side = side[SQ_STAGES-1];
endmodule
`default_nettype wire

@@ hw/rtl/vn_div.sv @@
// Pipelined restoring divider for the three components, one quotient bit per stage.
`default_nettype none
module vn_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_vld,
  input  wire logic [vn_pkg::WORD_W-1:0]   in_len,
  input  wire vn_pkg::side_t               in_side,
  output logic                             out_vld,
  output logic [vn_pkg::WORD_W-1:0]        out_len,
  output logic                             out_zero,
  output logic [2:0]                       out_neg,
  output logic [2:0][vn_pkg::Q_W-1:0]      out_q
);
  import vn_pkg::*;

  logic [DV_STAGES-1:0] vld;
  logic [WORD_W-1:0]    len  [0:DV_STAGES-1];
  logic                 zero [0:DV_STAGES-1];
  logic [2:0]           neg  [0:DV_STAGES-1];
  logic [2:0][WORD_W-1:0] rem [0:DV_STAGES-1];
  logic [2:0][Q_W-1:0]    q   [0:DV_STAGES-1];

  logic [WORD_W-1:0]      c_len [0:DV_STAGES-1];
  logic [2:0][WORD_W-1:0] c_rem [0:DV_STAGES-1];
  logic [2:0][Q_W-1:0]    c_q   [0:DV_STAGES-1];
  logic [2:0][WORD_W:0]   c_sh  [0:DV_STAGES-1];
  logic [2:0][WORD_W:0]   c_dif [0:DV_STAGES-1];
  logic [2:0]             c_ge  [0:DV_STAGES-1];

  always_comb begin
    for (int i = 0; i < DV_STAGES; i++) begin
      if (i == 0) begin
        c_len[i] = in_len;
        c_rem[i] = in_side.mag;
        c_q[i]   = '0;
      end else begin
        c_len[i] = len[i-1];
        c_rem[i] = rem[i-1];
        c_q[i]   = q[i-1];
      end
      for (int l = 0; l < 3; l++) begin
        c_sh[i][l]  = (i == 0) ? {1'b0, c_rem[i][l]} : {c_rem[i][l], 1'b0};
        c_dif[i][l] = c_sh[i][l] - {1'b0, c_len[i]};
        c_ge[i][l]  = c_sh[i][l] >= {1'b0, c_len[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DV_STAGES; i++) begin
      len[i]  <= c_len[i];
      zero[i] <= (i == 0) ? (in_len == '0) : zero[i-1];
      neg[i]  <= (i == 0) ? in_side.neg : neg[i-1];
      for (int l = 0; l < 3; l++) begin
        rem[i][l] <= c_ge[i][l] ? c_dif[i][l][WORD_W-1:0] : c_sh[i][l][WORD_W-1:0];
        q[i][l]   <= {c_q[i][l][Q_W-2:0], c_ge[i][l]};
      end
    end
  end

  assign out_vld  = vld[DV_STAGES-1];
  assign out_len  = len[DV_STAGES-1];
  assign out_zero = zero[DV_STAGES-1];
  assign out_neg  = neg[DV_STAGES-1];
  assign out_q    = q[DV_STAGES-1];
endmodule
`default_nettype wire

@@ hw/rtl/vector3_normalize.sv @@
// Top level of the 3D vector normalization pipeline.
// Usage: drive coord with an item and raise start for one cycle per item.
// busy is always low, so an item is taken at every edge where start is high;
// a new item may follow in every cycle, for one item per clock sustained.
// Each item gives exactly one result on the result port, marked by done for
// a single cycle. The pipeline runs through magnitudes, squares, two adder
// stages, 32 square-root stages (one root bit each), 31 divider stages (one
// quotient bit each for all three components) and the output register.
// Results leave in the order the items arrived.
// magnitude is the truncated length in the input's Q16.16 format, and the
// unit components are signed Q2.30, truncated toward zero.
// A zero vector gives zero components and length with was_zero set.
// The receiver cannot stall; it must take each result in its done cycle.
// A synchronous reset drops every item in flight and clears done.
`default_nettype none
`include "assert_macros.svh"
module vector3_normalize (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire vn_pkg::coord_t  coord,
  output logic                 done,
  output vn_pkg::result_t      result
);
  import vn_pkg::*;

  logic                   v1, v2, v3, v4;
  side_t                  side1, side2, side3, side4;
  logic [SUM_W-1:0]       sq_x, sq_y, sq_z, sq_z3, sum_xy, sum;
  logic [2:0][WORD_W-1:0] mag_c;
  logic [2:0]             neg_c;
  logic [WORD_W-1:0]      raw [0:2];

  logic                   sq_vld;
  logic [WORD_W-1:0]      sq_root;
  side_t                  sq_side;

  logic                   dv_vld, dv_zero;
  logic [WORD_W-1:0]      dv_len;
  logic [2:0]             dv_neg;
  logic [2:0][Q_W-1:0]    dv_q;
  logic [2:0][WORD_W-1:0] unit_c;
  logic [Q_W-1:0]         q_sat;

  assign busy = 1'b0;

  always_comb begin
    raw[0] = coord.coord_x;
    raw[1] = coord.coord_y;
    raw[2] = coord.coord_z;
    for (int l = 0; l < 3; l++) begin
      neg_c[l] = raw[l][WORD_W-1];
      mag_c[l] = neg_c[l] ? (~raw[l] + WORD_W'(1)) : raw[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    side1.mag <= mag_c;
    side1.neg <= neg_c;
    side2     <= side1;
    sq_x      <= side1.mag[0] * side1.mag[0];
    sq_y      <= side1.mag[1] * side1.mag[1];
    sq_z      <= side1.mag[2] * side1.mag[2];
    side3     <= side2;
    sum_xy    <= sq_x + sq_y;
    sq_z3     <= sq_z;
    side4     <= side3;
    sum       <= sum_xy + sq_z3;
  end

  vn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (v4),
    .in_rad   (sum),
    .in_side  (side4),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  vn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sq_vld),
    .in_len   (sq_root),
    .in_side  (sq_side),
    .out_vld  (dv_vld),
    .out_len  (dv_len),
    .out_zero (dv_zero),
    .out_neg  (dv_neg),
    .out_q    (dv_q)
  );

  always_comb begin
    q_sat = '0;
    for (int l = 0; l < 3; l++) begin
      q_sat = (dv_q[l] > UNIT_ONE) ? UNIT_ONE : dv_q[l];
      if (dv_zero) begin
        unit_c[l] = '0;
      end else if (dv_neg[l]) begin
        unit_c[l] = ~{1'b0, q_sat} + WORD_W'(1);
      end else begin
        unit_c[l] = {1'b0, q_sat};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    result.unit_x    <= unit_c[0];
    result.unit_y    <= unit_c[1];
    result.unit_z    <= unit_c[2];
    result.magnitude <= dv_len;
    result.was_zero  <= dv_zero;
  end

  `VN_ASSERT_ALWAYS(a_never_busy, clk, !busy)
  `VN_ASSERT_RST(a_zero_len, clk, rst, done |-> (result.was_zero == (result.magnitude == '0)))
  `VN_ASSERT_RST(a_zero_units, clk, rst,
    (done && result.was_zero) |-> (result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0))
  `VN_ASSERT_RST(a_unit_range, clk, rst,
    done |-> (result.unit_x <= 32'sh4000_0000 && result.unit_x >= -32'sh4000_0000))
endmodule
`default_nettype wire

@@ dv/vector3_normalize_checker.sv @@
// Checker that predicts and compares the results of the vector normalization block.
`timescale 1ns / 100ps
`default_nettype none
module vector3_normalize_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire vn_pkg::coord_t  coord,
  input  wire logic            done,
  input  wire vn_pkg::result_t result,
  output int                   fail_count,
  output int                   pending
);
  import vn_pkg::*;

  result_t expected_results[$];

  function automatic logic [63:0] root_of(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] unit_part(input logic [31:0] c, input logic [63:0] len);
    logic [63:0] m;
    logic [63:0] q;
    if (len == 0) return 32'd0;
    m = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
    q = (m << 30) / len;
    if (q > 64'h4000_0000) q = 64'h4000_0000;
    return c[31] ? 32'(64'h1_0000_0000 - q) : q[31:0];
  endfunction

  function automatic result_t normalize(input coord_t c);
    result_t r;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] mz;
    logic [63:0] len;
    mx = c.coord_x[31] ? 64'h1_0000_0000 - {32'd0, c.coord_x} : {32'd0, c.coord_x};
    my = c.coord_y[31] ? 64'h1_0000_0000 - {32'd0, c.coord_y} : {32'd0, c.coord_y};
    mz = c.coord_z[31] ? 64'h1_0000_0000 - {32'd0, c.coord_z} : {32'd0, c.coord_z};
    len = root_of(mx * mx + my * my + mz * mz);
    r.unit_x = unit_part(c.coord_x, len);
    r.unit_y = unit_part(c.coord_y, len);
    r.unit_z = unit_part(c.coord_z, len);
    r.magnitude = len[31:0];
    r.was_zero = (len == 0);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t e;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) expected_results = {expected_results, normalize(coord)};
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errs++;
        end else begin
          e = expected_results.pop_front();
          if (result.unit_x !== e.unit_x) begin
            $error("unit_x expected %h actual %h", e.unit_x, result.unit_x);
            errs++;
          end
          if (result.unit_y !== e.unit_y) begin
            $error("unit_y expected %h actual %h", e.unit_y, result.unit_y);
            errs++;
          end
          if (result.unit_z !== e.unit_z) begin
            $error("unit_z expected %h actual %h", e.unit_z, result.unit_z);
            errs++;
          end
          if (result.magnitude !== e.magnitude) begin
            $error("magnitude expected %h actual %h", e.magnitude, result.magnitude);
            errs++;
          end
          if (result.was_zero !== e.was_zero) begin
            $error("was_zero expected %b actual %b", e.was_zero, result.was_zero);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule
`default_nettype wire

@@ dv/vector3_normalize_tb.sv @@
// Testbench top that drives vectors into the normalization block and gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module vector3_normalize_tb;
  import vn_pkg::*;

  localparam int RANDOM_ITEMS = 1830;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  coord_t  coord = '0;
  logic    done;
  result_t result;
  int      fail_count;
  int      pending;
  int      quiet_cycles = 0;

  always #5 clk = ~clk;

  vector3_normalize uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord(coord), .done(done), .result(result)
  );

  vector3_normalize_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .coord(coord),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 512)) - 256);
      3: return 32'd0;
      4: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    coord <= '{coord_x: x, coord_y: y, coord_z: z};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [31:0] edge_vals [8];
    int n;
    edge_vals = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff,
                  32'h0001_0000, 32'hffff_0000, 32'h5555_aaaa};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_item(0, 0, 0, 1'b0);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 0, 0, 1'b1);
    send_item(0, 32'h7fff_ffff, 0, 1'b1);
    send_item(0, 0, 32'hffff_ffff, 1'b1);
    send_item(32'h1, 0, 0, 1'b0);
    send_item(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 1'b0);
    for (n = 0; n < 16; n++) begin
      send_item(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)],
                edge_vals[$urandom_range(0, 7)], 1'b1);
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(pick_coord(), pick_coord(), pick_coord(), n < RANDOM_ITEMS - 200);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ vector3_normalize.f @@
+incdir+hw/rtl
hw/rtl/vn_pkg.sv
hw/rtl/vn_sqrt.sv
hw/rtl/vn_div.sv
hw/rtl/vector3_normalize.sv
dv/vector3_normalize_checker.sv
dv/vector3_normalize_tb.sv
